### src/plse_pkg.sv
package plse_pkg;

  // Size of the message store in bytes. The store is split into an even and
  // an odd bank so that two neighboring bytes can be read in the same cycle.
  localparam int MSG_BYTES  = 4096;
  localparam int MSG_AW     = $clog2(MSG_BYTES);
  localparam int BANK_DEPTH = MSG_BYTES / 2;
  localparam int BANK_AW    = MSG_AW - 1;
  localparam int LOAD_PTR_W = MSG_AW + 1;

  localparam int LEN_W     = 13;
  localparam int BPP_W     = 3;
  localparam int BIT_PTR_W = 16;
  localparam int CFG_W     = 13;
  localparam int DATA_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int KMAX      = 4;
  localparam int CNT_W     = 4;

  localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
  localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_PIXEL   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_BITS_PER_PIXEL = 1'b0,
    REG_MESSAGE_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] data;
    logic              final_pixel;
  } plse_in_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic              last_of_run;
    logic              message_left_over;
  } plse_out_t;

  // Work handed from the front end to the embed stage.
  typedef struct packed {
    logic              is_pixel;
    logic [DATA_W-1:0] data;     // palette word, or shifted pixel in the low byte
    logic [2:0]        off;      // bit offset inside the first message byte
    logic [BPP_W-1:0]  k;        // effective bits per pixel
    logic [BPP_W-1:0]  n;        // message bits actually taken
    logic              odd;      // first byte lives in the odd bank
    logic              left;     // message bits remain after the final pixel
  } plse_op_t;

  // Request to the two message banks.
  typedef struct packed {
    logic               we0;
    logic               we1;
    logic [BANK_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [BANK_AW-1:0] raddr0;
    logic [BANK_AW-1:0] raddr1;
  } plse_mem_req_t;

endpackage

### src/plse_ram.sv
module plse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/plse_ctrl.sv
module plse_ctrl
  import plse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  plse_in_t      in_data,
  input  logic          s1_free,
  output logic          op_valid,
  output plse_op_t      op,
  output plse_mem_req_t mem_req
);

  logic [BPP_W-1:0]      bpp_r, bpp_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LOAD_PTR_W-1:0] load_ptr_r, load_ptr_nxt;
  logic [BIT_PTR_W-1:0]  bit_ptr_r, bit_ptr_nxt;

  logic                  accept;
  logic                  cfg_we;
  cmd_t                  cmd;
  logic [BPP_W-1:0]      k;
  logic [LEN_W-1:0]      len_eff;
  logic [BIT_PTR_W-1:0]  total;
  logic [BIT_PTR_W-1:0]  remaining;
  logic [BPP_W-1:0]      take;
  logic [BIT_PTR_W-1:0]  ptr_adv;
  logic [MSG_AW-1:0]     idx;
  logic                  store_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_ready  = s1_free;
  assign accept    = in_valid && in_ready;
  assign cmd       = cmd_t'(in_data.cmd);

  always_comb begin
    if (bpp_r < BPP_MIN) begin
      k = BPP_MIN;
    end else if (bpp_r > BPP_MAX) begin
      k = BPP_MAX;
    end else begin
      k = bpp_r;
    end
  end

  assign len_eff    = (len_r > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : len_r;
  assign total      = BIT_PTR_W'({len_eff, 3'b000});
  assign remaining  = total - bit_ptr_r;
  assign store_full = (load_ptr_r >= LOAD_PTR_W'(MSG_BYTES));
  assign idx        = bit_ptr_r[MSG_AW+2:3];

  always_comb begin
    if (bit_ptr_r >= total) begin
      take = '0;
    end else if (remaining < BIT_PTR_W'(k)) begin
      take = remaining[BPP_W-1:0];
    end else begin
      take = k;
    end
  end

  assign ptr_adv = bit_ptr_r + BIT_PTR_W'(take);

  // Work for the embed stage.
  always_comb begin
    op          = '0;
    op_valid    = 1'b0;
    op.k        = k;
    op.n        = take;
    op.off      = bit_ptr_r[2:0];
    op.odd      = idx[0];
    op.left     = in_data.final_pixel && (ptr_adv < total);
    case (cmd)
      CMD_PALETTE: begin
        op_valid    = accept;
        op.is_pixel = 1'b0;
        op.data     = in_data.data;
      end
      CMD_PIXEL: begin
        op_valid    = accept;
        op.is_pixel = 1'b1;
        op.data     = DATA_W'(BYTE_W'(in_data.data[BYTE_W-1:0] << k));
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  // Bank accesses: loads write one bank, a pixel reads both.
  always_comb begin
    mem_req        = '0;
    mem_req.waddr  = load_ptr_r[MSG_AW-1:1];
    mem_req.wdata  = in_data.data[BYTE_W-1:0];
    mem_req.we0    = accept && (cmd == CMD_LOAD) && !store_full && !load_ptr_r[0];
    mem_req.we1    = accept && (cmd == CMD_LOAD) && !store_full && load_ptr_r[0];
    mem_req.re     = accept && (cmd == CMD_PIXEL);
    mem_req.raddr0 = idx[MSG_AW-1:1] + BANK_AW'(idx[0]);
    mem_req.raddr1 = idx[MSG_AW-1:1];
  end

  always_comb begin
    bpp_nxt      = bpp_r;
    len_nxt      = len_r;
    load_ptr_nxt = load_ptr_r;
    bit_ptr_nxt  = bit_ptr_r;
    if (accept && (cmd == CMD_LOAD) && !store_full) begin
      load_ptr_nxt = load_ptr_r + LOAD_PTR_W'(1);
    end
    if (accept && (cmd == CMD_PIXEL)) begin
      bit_ptr_nxt = in_data.final_pixel ? '0 : ptr_adv;
    end
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BITS_PER_PIXEL: begin
          bpp_nxt = cfg_data[BPP_W-1:0];
        end
        REG_MESSAGE_LENGTH: begin
          len_nxt      = cfg_data[LEN_W-1:0];
          load_ptr_nxt = '0;
          bit_ptr_nxt  = '0;
        end
        default: begin
          bpp_nxt = bpp_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= BPP_MIN;
      len_r      <= '0;
      load_ptr_r <= '0;
      bit_ptr_r  <= '0;
    end else begin
      bpp_r      <= bpp_nxt;
      len_r      <= len_nxt;
      load_ptr_r <= load_ptr_nxt;
      bit_ptr_r  <= bit_ptr_nxt;
    end
  end

endmodule

### src/plse_embed.sv
module plse_embed
  import plse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  plse_op_t          op,
  input  logic [BYTE_W-1:0] rd0,
  input  logic [BYTE_W-1:0] rd1,
  input  logic              push_ok,
  output logic              s1_free,
  output logic              push_valid,
  output plse_out_t         push_data
);

  logic             s1_valid_r, s1_valid_nxt;
  plse_op_t         s1_op_r, s1_op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic              advance;
  logic              last;
  logic [BYTE_W-1:0] byte_a;
  logic [BYTE_W-1:0] byte_b;
  logic [15:0]       window;
  logic [KMAX-1:0]   top;
  logic [KMAX-1:0]   bits;
  logic [KMAX-1:0]   keep;
  logic [BYTE_W-1:0] pix;

  assign advance    = s1_valid_r && push_ok;
  assign last       = (cnt_r == '0);
  assign s1_free    = !s1_valid_r || (advance && last);
  assign push_valid = advance;

  // The two banks hold neighboring bytes; the parity picks which is first.
  assign byte_a = s1_op_r.odd ? rd1 : rd0;
  assign byte_b = s1_op_r.odd ? rd0 : rd1;
  assign window = {byte_a, byte_b} << s1_op_r.off;
  assign top    = window[15:12];
  assign bits   = top >> (3'(KMAX) - s1_op_r.k);
  // Bits past the end of the message read as zero.
  assign keep   = KMAX'(4'hF << (s1_op_r.k - s1_op_r.n));
  assign pix    = s1_op_r.data[BYTE_W-1:0] | BYTE_W'(bits & keep);

  always_comb begin
    push_data = '0;
    if (s1_op_r.is_pixel) begin
      push_data.kind              = KIND_PIXEL;
      push_data.value             = DATA_W'(pix);
      push_data.last_of_run       = 1'b1;
      push_data.message_left_over = s1_op_r.left;
    end else begin
      push_data.kind              = KIND_PALETTE;
      push_data.value             = s1_op_r.data;
      push_data.last_of_run       = last;
      push_data.message_left_over = 1'b0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_op_nxt    = s1_op_r;
    cnt_nxt      = cnt_r;
    if (op_valid) begin
      s1_valid_nxt = 1'b1;
      s1_op_nxt    = op;
      cnt_nxt      = op.is_pixel ? '0 : CNT_W'((5'd1 << op.k) - 5'd1);
    end else if (advance && last) begin
      s1_valid_nxt = 1'b0;
    end else if (advance) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
    s1_op_r <= s1_op_nxt;
  end

endmodule

### src/plse_skid.sv
module plse_skid
  import plse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  plse_out_t push_data,
  output logic      push_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output plse_out_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  plse_out_t out_r, out_nxt;
  plse_out_t skid_r, skid_nxt;

  assign push_ok   = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push_valid;
      end
    end else if (push_valid) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### src/palette_stretch_lsb_embed_top.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    plse_in_t  (cmd, data, final_pixel)
// out_      output     out_valid / out_ready  plse_out_t (kind, value, last_of_run,
//                                                         message_left_over)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load or pixel request is taken when the embed stage is free; a palette request
// holds the input until all 2^k copies are sent, as the single result port sends one
// copy a cycle unless the output stalls. A request and its bank read are registered
// in the embed stage, then its result in the output register. Reset is synchronous
// and active low; the message banks are not cleared and hold nothing valid until
// loaded. A stalled output fills a one-entry skid buffer, then the input stalls too.
module palette_stretch_lsb_embed_top
  import plse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  plse_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output plse_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Front end to embed stage.
  logic          op_valid;
  plse_op_t      op;
  logic          s1_free;
  plse_mem_req_t mem_req;

  // Embed stage to output buffer.
  logic          push_valid;
  logic          push_ok;
  plse_out_t     push_data;

  logic [BYTE_W-1:0] rd0;
  logic [BYTE_W-1:0] rd1;

  // The front end holds the configuration and both message pointers. It
  // works out how many message bits each pixel takes, so the pointers move on
  // in the cycle of the request while the bytes are still being read.
  plse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .s1_free   (s1_free),
    .op_valid  (op_valid),
    .op        (op),
    .mem_req   (mem_req)
  );

  // Even message bytes live in bank 0 and odd bytes in bank 1, so the byte
  // under the bit pointer and the one after it are read in the same cycle.
  plse_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (mem_req.we0),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr0),
    .rdata (rd0)
  );

  plse_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (mem_req.we1),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr1),
    .rdata (rd1)
  );

  // The embed stage merges the read bytes into the pixel, or repeats a
  // palette word once per copy. Read data stays put while it waits, since the
  // banks are only read when a new request is taken.
  plse_embed u_embed (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op         (op),
    .rd0        (rd0),
    .rd1        (rd1),
    .push_ok    (push_ok),
    .s1_free    (s1_free),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Output register with a skid entry keeps out_ready off the input path.
  plse_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ok    (push_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  // The embed stage never pushes a result into a full skid buffer.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ok)
    else $error("result pushed while the skid entry is full");

  // New work reaches the embed stage only when it has room for it.
  a_op_room: assert property (@(posedge clk) disable iff (!rst_n)
    op_valid |-> s1_free)
    else $error("request taken while the embed stage is busy");

  // Palette copies never carry the left-over flag.
  a_palette_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == KIND_PALETTE)) |-> !out_data.message_left_over)
    else $error("palette copy flagged with left-over message bits");

  // A pixel result is always a byte wide and ends its run.
  a_pixel_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == KIND_PIXEL)) |->
      (out_data.last_of_run && (out_data.value[DATA_W-1:BYTE_W] == '0)))
    else $error("malformed pixel result");
`endif

endmodule

### bench/palette_stretch_lsb_embed_top_tb.sv
module palette_stretch_lsb_embed_top_tb;
  import plse_pkg::*;

  // The clock runs freely and reset is held low until the stimulus process releases it.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  // Every input of the block starts at a known value.
  logic in_valid = 1'b0;
  logic in_ready;
  plse_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  plse_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  palette_stretch_lsb_embed_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Requests waiting to be offered, and the palette copies and stego pixels that the
  // accepted requests must still produce, oldest first.
  plse_in_t requests_to_send[$];
  plse_out_t words_due[$];

  // Handshakes seen at the last rising edge. The falling-edge processes read these
  // instead of sampling the ready lines themselves.
  logic in_fire_q = 1'b0;
  logic cfg_fire_q = 1'b0;

  int fail_count = 0;

  // Idling rates in percent, set per phase by the stimulus process.
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus process bumps rx_hold_reqs to ask for one long receiver stall.
  // The receiver counts the stall down on its own.
  int rx_hold_reqs = 0;
  int rx_hold_seen = 0;
  int hold_left = 0;

  // Our own copy of the block's state, advanced at every accepted request or
  // register write.
  logic [7:0] msg_bytes [MSG_BYTES];
  int ld_ptr = 0;
  int bit_ptr = 0;
  logic [BPP_W-1:0] cur_bpp = BPP_MIN;
  logic [LEN_W-1:0] cur_len = '0;

  // A lighter copy of the pointers, advanced as requests are queued. The generator
  // uses it to make sure no pixel ever pulls bits from a byte that was never loaded.
  // Loads always fill the store from byte zero upward, so the written bytes are
  // always a prefix of length gen_hw.
  int gen_k = 1;
  int gen_total = 0;
  int gen_ld = 0;
  int gen_hw = 0;
  int gen_bit = 0;

  // Bits per pixel below one act as one, and above four act as four.
  function automatic int effective_k(input logic [BPP_W-1:0] bpp);
    if (bpp < BPP_MIN) return BPP_MIN;
    if (bpp > BPP_MAX) return BPP_MAX;
    return bpp;
  endfunction

  // Message length in bits, with lengths past the store size capped to the store.
  function automatic int message_bits(input logic [LEN_W-1:0] len);
    return ((len > MSG_BYTES) ? MSG_BYTES : int'(len)) * 8;
  endfunction

  // Works out what one accepted request does to the state and which words it
  // must produce.
  task automatic stretch_and_embed(input plse_in_t req);
    int k;
    int total;
    int copies;
    logic [7:0] pix;
    logic [7:0] hidden;
    plse_out_t word;
    k = effective_k(cur_bpp);
    total = message_bits(cur_len);
    copies = 1 << k;
    word = '0;
    case (cmd_t'(req.cmd))
      CMD_LOAD: begin
        // Loads past the end of the store are dropped.
        if (ld_ptr < MSG_BYTES) begin
          msg_bytes[ld_ptr] = req.data[7:0];
          ld_ptr++;
        end
      end
      CMD_PALETTE: begin
        // One copy per pixel value that the k hidden bits can turn one index into.
        for (int c = 0; c < copies; c++) begin
          word.kind = KIND_PALETTE;
          word.value = req.data;
          word.last_of_run = (c == copies - 1);
          word.message_left_over = 1'b0;
          words_due.push_back(word);
        end
      end
      CMD_PIXEL: begin
        pix = 8'(req.data[7:0] << k);
        hidden = '0;
        // Message bits go in most significant first. Once the message runs out
        // partway through a pixel, the remaining low bits are zero.
        if (bit_ptr < total) begin
          for (int b = 0; b < k; b++) begin
            if (bit_ptr < total) begin
              hidden = {hidden[6:0], msg_bytes[bit_ptr >> 3][7 - (bit_ptr & 7)]};
              bit_ptr++;
            end else begin
              hidden = {hidden[6:0], 1'b0};
            end
          end
        end
        word.kind = KIND_PIXEL;
        word.value = {24'b0, pix | hidden};
        word.last_of_run = 1'b1;
        word.message_left_over = req.final_pixel && (bit_ptr < total);
        // The next image embeds the message again from its first bit.
        if (req.final_pixel) bit_ptr = 0;
        words_due.push_back(word);
      end
      default: begin
        // The spare command code is dropped without a result.
      end
    endcase
  endtask

  // Reports one failure with what was expected and what came out.
  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $error("%s: expected %0h, got %0h", what, want, got);
    fail_count++;
  endtask

  // Rising edge: note the handshakes, keep our state in step with the block, and
  // compare every word that leaves it with the oldest one still due.
  always @(posedge clk) begin : monitor
    plse_out_t due;
    in_fire_q <= rst_n && in_valid && in_ready;
    cfg_fire_q <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          report("unexpected result value", 32'h0, out_data.value);
        end else begin
          due = words_due.pop_front();
          if (out_data.kind !== due.kind) report("kind", due.kind, out_data.kind);
          if (out_data.value !== due.value) report("value", due.value, out_data.value);
          if (out_data.last_of_run !== due.last_of_run)
            report("last_of_run", due.last_of_run, out_data.last_of_run);
          if (out_data.message_left_over !== due.message_left_over)
            report("message_left_over", due.message_left_over, out_data.message_left_over);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BITS_PER_PIXEL) begin
          cur_bpp = cfg_data[BPP_W-1:0];
        end else begin
          // A new length starts a new message: both pointers go back to zero.
          cur_len = cfg_data;
          ld_ptr = 0;
          bit_ptr = 0;
        end
      end
      if (in_valid && in_ready) stretch_and_embed(in_data);
    end
  end

  // Falling edge: offer the next request once the previous one has been taken.
  // A request that is up stays up, unchanged, until the block accepts it.
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= requests_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Falling edge: the result side stalls at random, and now and then holds off
  // for a long stretch so that the block backs up into its input.
  always @(negedge clk) begin : receiver
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen <= rx_hold_reqs;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queues one request and advances the generator's pointers. Before a pixel that
  // draws message bits, it queues loads until every byte it needs is in the store.
  task automatic queue_request(input cmd_t cmd, input logic [31:0] data, input logic fin);
    plse_in_t req;
    int n;
    req.cmd = cmd;
    req.data = data;
    req.final_pixel = fin;
    if (cmd == CMD_LOAD && gen_ld < MSG_BYTES) begin
      gen_ld++;
      if (gen_ld > gen_hw) gen_hw = gen_ld;
    end
    if (cmd == CMD_PIXEL) begin
      n = 0;
      if (gen_bit < gen_total) n = (gen_total - gen_bit < gen_k) ? gen_total - gen_bit : gen_k;
      while (n != 0 && ((gen_bit + n - 1) >> 3) >= gen_hw)
        queue_request(CMD_LOAD, $urandom, 1'b0);
      gen_bit = fin ? 0 : gen_bit + n;
    end
    requests_to_send.push_back(req);
  endtask

  // Waits until every queued request has gone in and every due word has come out,
  // then lets the clock run on, since a trailing load leaves no word to wait for.
  task automatic settle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_valid || words_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire_q);
    cfg_valid <= 1'b0;
    if (idx == REG_BITS_PER_PIXEL) begin
      gen_k = effective_k(val[BPP_W-1:0]);
    end else begin
      gen_total = message_bits(val);
      gen_ld = 0;
      gen_bit = 0;
    end
  endtask

  // Mostly pixel runs that end in a final pixel, so that images of random length
  // form, with palette entries, loads and the spare command mixed in.
  task automatic random_traffic(input int n);
    int pick;
    @(posedge clk);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 10) queue_request(CMD_PALETTE, $urandom, 1'($urandom));
      else if (pick < 18) queue_request(CMD_LOAD, $urandom, 1'($urandom));
      else if (pick < 21) queue_request(CMD_NONE, $urandom, 1'($urandom));
      else queue_request(CMD_PIXEL, $urandom, $urandom_range(7) == 0);
    end
  endtask

  initial begin : stimulus
    int ph_bpp [8];
    int ph_len [8];
    ph_bpp = '{1, 2, 3, 4, 5, 0, 6, 4};
    ph_len = '{2, 17, 300, 4096, 8191, 0, 1, 9};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A three byte message, with bits per pixel written as zero so it acts as one.
    write_reg(REG_MESSAGE_LENGTH, 13'd3);
    write_reg(REG_BITS_PER_PIXEL, 13'd0);
    @(posedge clk);
    // The spare command is dropped, even with every data bit and the final flag set.
    queue_request(CMD_NONE, 32'hFFFF_FFFF, 1'b1);
    // Only the low byte of a load is stored.
    queue_request(CMD_LOAD, 32'hFFFF_FFA5, 1'b0);
    queue_request(CMD_LOAD, 32'h0000_0000, 1'b0);
    queue_request(CMD_LOAD, 32'h1234_56FF, 1'b0);
    queue_request(CMD_PALETTE, 32'h0000_0000, 1'b0);
    queue_request(CMD_PALETTE, 32'hFFFF_FFFF, 1'b0);
    // A short image ends with most of the message still unembedded.
    queue_request(CMD_PIXEL, 32'h0000_00FF, 1'b0);
    queue_request(CMD_PIXEL, 32'hFFFF_FF00, 1'b0);
    queue_request(CMD_PIXEL, 32'h0000_0080, 1'b1);

    // Four bits per pixel: sixteen copies per palette entry, and the whole message
    // fits in six pixels, so the seventh passes through only shifted.
    write_reg(REG_BITS_PER_PIXEL, 13'd4);
    @(posedge clk);
    queue_request(CMD_PALETTE, 32'hDEAD_BEEF, 1'b0);
    repeat (6) queue_request(CMD_PIXEL, $urandom, 1'b0);
    queue_request(CMD_PIXEL, 32'hFFFF_FFFF, 1'b1);

    // Seven acts as four. The message now ends exactly on the final pixel.
    write_reg(REG_BITS_PER_PIXEL, 13'd7);
    @(posedge clk);
    repeat (5) queue_request(CMD_PIXEL, $urandom, 1'b0);
    queue_request(CMD_PIXEL, $urandom, 1'b1);

    // An empty message leaves pixels only shifted.
    write_reg(REG_MESSAGE_LENGTH, 13'd0);
    @(posedge clk);
    queue_request(CMD_PIXEL, 32'h0000_00FF, 1'b1);

    // An oversized length acts as the full store, which never fits in one pixel.
    write_reg(REG_MESSAGE_LENGTH, 13'h1FFF);
    @(posedge clk);
    queue_request(CMD_PIXEL, 32'h0000_0055, 1'b1);

    // Random phases over several settings, each with its own idling pattern.
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_MESSAGE_LENGTH, 13'(ph_len[p]));
      write_reg(REG_BITS_PER_PIXEL, {10'($urandom), 3'(ph_bpp[p])});
      @(posedge clk);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 51;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 51;
        end
        default: begin
          sender_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      random_traffic(22);
      // In the phases without idling, the receiver stops for a long stretch while
      // the sender keeps pushing, so the block fills and stalls its input.
      if (p % 4 == 0) rx_hold_reqs++;
      // The sender then pauses until every due word has come back.
      settle();
      random_traffic(22);
    end

    settle();
    repeat (8) @(negedge clk);
    if (words_due.size() != 0) begin
      $error("%0d results never arrived", words_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("palette_stretch_lsb_embed_top verification clean");
    end else begin
      $display("palette_stretch_lsb_embed_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #3600000;
    $display("palette_stretch_lsb_embed_top verification failed");
    $finish;
  end

endmodule

### files.f
src/plse_pkg.sv
src/plse_ram.sv
src/plse_ctrl.sv
src/plse_embed.sv
src/plse_skid.sv
src/palette_stretch_lsb_embed_top.sv
bench/palette_stretch_lsb_embed_top_tb.sv
